[src/fwks_pkg.sv]
package fwks_pkg;

   // Queue depth used when the top level is not given another.
   localparam int unsigned DEFAULT_DEPTH = 16;

   // Field widths of the channels.
   localparam int unsigned KEY_W = 32;
   localparam int unsigned OP_W  = 3;
   localparam int unsigned POS_W = 4;
   localparam int unsigned OCC_W = 5;

   // The search scanner inspects this many cells per cycle.
   localparam int unsigned SCAN_GROUP   = 8;
   localparam int unsigned SCAN_GROUP_W = $clog2(SCAN_GROUP);

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_SEARCH  = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic signed [KEY_W-1:0] key;
   } req_payload_type;

   typedef struct packed {
      logic                    ok;
      logic signed [KEY_W-1:0] key_out;
      logic signed [KEY_W-1:0] last_key;
      logic                    found;
      logic [POS_W-1:0]        position;
      logic [OCC_W-1:0]        occupancy;
   } rsp_payload_type;

   // Commands broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                    write;
      logic                    shift;
      logic                    capture;
      logic signed [KEY_W-1:0] key;
   } cell_ctrl_type;

   // Status handed from the search scanner back to the controller.
   typedef struct packed {
      logic             idle;
      logic             done;
      logic             found;
      logic [POS_W-1:0] position;
   } scan_status_type;

endpackage

[src/fwks_chan_if.sv]
interface fwks_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

[src/fifo_with_key_search_core.sv]
// First-in first-out queue of signed 32-bit keys with a key search.
// The req channel carries one operation and a key per transfer: enqueue,
// dequeue, peek at first and last, search, or clear. The rsp channel returns
// exactly one result per request, in order, with ok, the keys read, the
// search outcome and the occupancy after the operation.
// Entries sit in a chain of cells aligned to the head: enqueue writes the
// cell at the current occupancy, dequeue moves every key one cell down.
// Every operation but search gives its result in the cycle after the request.
// A search compares every cell in its request cycle, then a scanner walks
// the match bits eight cells per cycle from the head and stops at the first
// group with a match or at the last group; no request is taken meanwhile.
// Other operations sustain one transfer per cycle while every result is taken.
// Results wait in an output register: while the receiver stalls, one result
// is held and a new request is taken only in a cycle where that register is
// empty or being drained.
// Reset empties the queue and the output register; stored keys are not
// cleared and are only read once written.
module fifo_with_key_search_core #(
   parameter int unsigned DEPTH = fwks_pkg::DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   fwks_chan_if.sink   req,
   fwks_chan_if.source rsp
);
   import fwks_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic signed [KEY_W-1:0] last_ff;
   logic signed [KEY_W-1:0] last_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_payload_type         rsp_data_ff;
   rsp_payload_type         rsp_data_in;

   logic                    accept;
   op_type                  op;
   cell_ctrl_type           ctrl;
   logic                    scan_start;
   scan_status_type         scan;
   logic                    load_now;
   rsp_payload_type         now_data;
   logic [CNT_W+OCC_W-1:0]  occ_cur_ext;

   logic signed [KEY_W-1:0] cell_data [DEPTH];
   logic signed [KEY_W-1:0] next_data [DEPTH];
   logic [DEPTH-1:0]        wr_sel;
   logic [DEPTH-1:0]        in_use;
   logic [DEPTH-1:0]        match;

   assign req.ready = scan.idle && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign op        = op_type'(req.payload.operation);

   // Decode the accepted operation into cell commands and an immediate result.
   always_comb begin
      count_in   = count_ff;
      last_in    = last_ff;
      scan_start = 1'b0;
      load_now   = 1'b0;
      ctrl.write   = 1'b0;
      ctrl.shift   = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.key     = req.payload.key;
      now_data.ok       = 1'b0;
      now_data.key_out  = '0;
      now_data.last_key = '0;
      now_data.found    = 1'b0;
      now_data.position = '0;
      if (accept) begin
         load_now = 1'b1;
         unique case (op)
            OP_ENQUEUE: begin
               if (count_ff != CNT_W'(DEPTH)) begin
                  ctrl.write  = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  last_in     = req.payload.key;
                  now_data.ok = 1'b1;
               end
            end
            OP_DEQUEUE: begin
               if (count_ff != '0) begin
                  ctrl.shift       = 1'b1;
                  count_in         = count_ff - CNT_W'(1);
                  now_data.key_out = cell_data[0];
                  now_data.ok      = 1'b1;
               end
            end
            OP_PEEK: begin
               if (count_ff != '0) begin
                  now_data.key_out  = cell_data[0];
                  now_data.last_key = last_ff;
                  now_data.ok       = 1'b1;
               end
            end
            OP_SEARCH: begin
               ctrl.capture = 1'b1;
               scan_start   = 1'b1;
               load_now     = 1'b0;
            end
            OP_CLEAR: begin
               count_in    = '0;
               now_data.ok = 1'b1;
            end
            default: begin
            end
         endcase
      end
      // The result reports the occupancy after the operation.
      now_data.occupancy = OCC_W'(count_in);
   end

   assign occ_cur_ext = {OCC_W'(0), count_ff};

   // Output register: loaded by an immediate result or a finished search.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      if (load_now) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = now_data;
      end else if (scan.done) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.ok        = 1'b1;
         rsp_data_in.key_out   = '0;
         rsp_data_in.last_key  = '0;
         rsp_data_in.found     = scan.found;
         rsp_data_in.position  = scan.position;
         rsp_data_in.occupancy = occ_cur_ext[OCC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // Chain of cells, index zero at the head of the queue.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign wr_sel[i] = (count_ff == CNT_W'(i));
      assign in_use[i] = (count_ff > CNT_W'(i));
      if (i == DEPTH - 1) begin : g_tail
         assign next_data[i] = cell_data[i];
      end else begin : g_inner
         assign next_data[i] = cell_data[i+1];
      end
      fwks_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .wr_sel    (wr_sel[i]),
         .in_use    (in_use[i]),
         .next_data (next_data[i]),
         .data      (cell_data[i]),
         .match     (match[i])
      );
   end

   fwks_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .match  (match),
      .status (scan)
   );

   // The occupancy never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond queue depth");

   // A search is taken only with the output register free or being drained, and it is then left empty.
   a_search_clear_out: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_SEARCH) |=> !rsp_valid_ff)
      else $error("output register busy during search");

   // A refused enqueue leaves the occupancy alone.
   a_full_enq: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_ENQUEUE && count_ff == CNT_W'(DEPTH)) |=> $stable(count_ff))
      else $error("full enqueue changed occupancy");

   // A successful dequeue removes exactly one entry.
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_DEQUEUE && count_ff != '0) |=>
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("dequeue did not remove one entry");

endmodule

[src/fwks_cell.sv]
module fwks_cell (
   input  logic                                      clock,
   input  fwks_pkg::cell_ctrl_type                   ctrl,
   input  logic                                      wr_sel,
   input  logic                                      in_use,
   input  logic signed [fwks_pkg::KEY_W-1:0]         next_data,
   output logic signed [fwks_pkg::KEY_W-1:0]         data,
   output logic                                      match
);
   import fwks_pkg::*;

   logic signed [KEY_W-1:0] data_ff;
   logic signed [KEY_W-1:0] data_in;
   logic                    match_ff;
   logic                    match_in;

   // A selected write takes the new key; a dequeue pulls the neighbour's key down.
   always_comb begin
      data_in = data_ff;
      if (ctrl.write && wr_sel) begin
         data_in = ctrl.key;
      end else if (ctrl.shift) begin
         data_in = next_data;
      end
   end

   // Only occupied cells may report a match.
   assign match_in = in_use && (data_ff == ctrl.key);

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.capture) begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

[src/fwks_scan.sv]
module fwks_scan #(
   parameter int unsigned DEPTH = fwks_pkg::DEFAULT_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DEPTH-1:0]          match,
   output fwks_pkg::scan_status_type status
);
   import fwks_pkg::*;

   localparam int unsigned NGROUP = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int unsigned GIDX_W = (NGROUP > 1) ? $clog2(NGROUP) : 1;

   typedef enum logic {
      SCAN_IDLE,
      SCAN_RUN
   } scan_state_type;

   scan_state_type                   state_ff;
   scan_state_type                   state_in;
   logic [GIDX_W-1:0]                grp_ff;
   logic [GIDX_W-1:0]                grp_in;
   logic [NGROUP*SCAN_GROUP-1:0]     match_pad;
   logic [SCAN_GROUP-1:0]            grp_bits;
   logic [SCAN_GROUP_W-1:0]          low;
   logic                             any;
   logic                             last;
   logic [GIDX_W+SCAN_GROUP_W-1:0]   full_pos;

   // Pad the match bits to whole groups so that the tail group reads zeros.
   always_comb begin
      match_pad = '0;
      match_pad[DEPTH-1:0] = match;
   end

   assign grp_bits = match_pad[grp_ff*SCAN_GROUP +: SCAN_GROUP];
   assign any      = |grp_bits;
   assign last     = (grp_ff == GIDX_W'(NGROUP - 1));

   // Lowest matching cell within the current group.
   always_comb begin
      low = '0;
      for (int b = SCAN_GROUP - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            low = SCAN_GROUP_W'(b);
         end
      end
   end

   assign full_pos = {grp_ff, low};

   // Walk the groups from the head until a match or the end of the chain.
   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      unique case (state_ff)
         SCAN_IDLE: begin
            if (start) begin
               state_in = SCAN_RUN;
               grp_in   = '0;
            end
         end
         SCAN_RUN: begin
            if (any || last) begin
               state_in = SCAN_IDLE;
            end else begin
               grp_in = grp_ff + GIDX_W'(1);
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         grp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
      end
   end

   assign status.idle     = (state_ff == SCAN_IDLE);
   assign status.done     = (state_ff == SCAN_RUN) && (any || last);
   assign status.found    = any;
   assign status.position = any ? full_pos[POS_W-1:0] : '0;

endmodule

[sim/tb_fifo_with_key_search_core.sv]
module tb_fifo_with_key_search_core;

   import fwks_pkg::*;

   localparam int unsigned QUEUE_DEPTH     = DEFAULT_DEPTH;
   localparam int unsigned RANDOM_ITEMS    = 600;
   localparam int unsigned PRESSURE_CYCLES = 200;
   localparam int unsigned SETTLE_CYCLES   = 20;
   localparam int unsigned DRAIN_LIMIT     = 20000;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   // Holds the expected queue contents and the results still owed by the block.
   class fifo_key_scoreboard;
      logic signed [KEY_W-1:0] held_keys[$];
      rsp_payload_type         owed_results[$];
      int unsigned             depth;
      int unsigned             mismatches;
      int unsigned             results_seen;

      function new(int unsigned depth_i);
         depth        = depth_i;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      task report(string msg);
         $display("[%0t] result %0d: %s", $time, results_seen, msg);
         mismatches++;
      endtask

      // Applies one accepted request to the queue copy and records its result.
      task note_request(req_payload_type item);
         rsp_payload_type owed;
         int              i;
         owed = '0;
         case (item.operation)
            OP_ENQUEUE: begin
               if (held_keys.size() < depth) begin
                  held_keys.push_back(item.key);
                  owed.ok = 1'b1;
               end
            end
            OP_DEQUEUE: begin
               if (held_keys.size() != 0) begin
                  owed.key_out = held_keys.pop_front();
                  owed.ok      = 1'b1;
               end
            end
            OP_PEEK: begin
               if (held_keys.size() != 0) begin
                  owed.key_out  = held_keys[0];
                  owed.last_key = held_keys[held_keys.size() - 1];
                  owed.ok       = 1'b1;
               end
            end
            OP_SEARCH: begin
               owed.ok = 1'b1;
               for (i = 0; i < held_keys.size(); i++) begin
                  if (held_keys[i] == item.key) begin
                     owed.found    = 1'b1;
                     owed.position = POS_W'(i);
                     break;
                  end
               end
            end
            OP_CLEAR: begin
               held_keys.delete();
               owed.ok = 1'b1;
            end
            default: begin
               // Unused operation codes change nothing and fail.
            end
         endcase
         owed.occupancy = OCC_W'(held_keys.size());
         owed_results.push_back(owed);
      endtask

      task check_field(string name, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
         if (got !== want)
            report($sformatf("%s is %h, expected %h", name, got, want));
      endtask

      // Compares one result transfer with the oldest result still owed.
      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (owed_results.size() == 0) begin
            report("result arrived with no request outstanding");
         end else begin
            want = owed_results.pop_front();
            check_field("ok", KEY_W'(got.ok), KEY_W'(want.ok));
            check_field("key_out", got.key_out, want.key_out);
            check_field("last_key", got.last_key, want.last_key);
            check_field("found", KEY_W'(got.found), KEY_W'(want.found));
            check_field("position", KEY_W'(got.position), KEY_W'(want.position));
            check_field("occupancy", KEY_W'(got.occupancy), KEY_W'(want.occupancy));
         end
         results_seen++;
      endtask
   endclass

   logic clock;
   logic reset;

   fwks_chan_if #(.payload_type(req_payload_type)) req_if ();
   fwks_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   fifo_with_key_search_core #(
      .DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   fifo_key_scoreboard key_board = new(QUEUE_DEPTH);

   int unsigned sent_items   = 0;
   bit          steady       = 1'b0;
   bit          hold_results = 1'b0;

   // Idle lengths: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      else if (roll < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Keys come from a small pool half of the time so that searches hit.
   function automatic logic signed [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 1) == 0)
         return $urandom;
      case ($urandom_range(0, 7))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2:       return 32'sd0;
         3:       return -32'sd1;
         4:       return 32'sd1;
         5:       return 32'sh5555_5555;
         6:       return 32'shAAAA_AAAA;
         default: return 32'sd7;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_operation();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return OP_ENQUEUE;
      else if (roll < 60)
         return OP_DEQUEUE;
      else if (roll < 70)
         return OP_PEEK;
      else if (roll < 92)
         return OP_SEARCH;
      else if (roll < 96)
         return OP_CLEAR;
      else
         return OP_W'($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_W) - 1));
   endfunction

   // Offers one request and waits for its transfer, then idles at random unless steady.
   task automatic send_item(input logic [OP_W-1:0] operation,
                            input logic signed [KEY_W-1:0] key);
      int unsigned gap;
      req_if.valid   <= 1'b1;
      req_if.payload <= '{operation: operation, key: key};
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      sent_items++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Clears the queue, fills it past full with consecutive keys, then looks them up.
   task automatic fill_and_search();
      logic signed [KEY_W-1:0] base;
      int                      i;
      base = $urandom;
      send_item(OP_CLEAR, $urandom);
      for (i = 0; i <= QUEUE_DEPTH; i++)
         send_item(OP_ENQUEUE, base + i);
      send_item(OP_PEEK, $urandom);
      send_item(OP_SEARCH, base + QUEUE_DEPTH - 1);
      repeat (3) send_item(OP_SEARCH, base + $urandom_range(0, QUEUE_DEPTH));
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   // Both transfers are sampled at the edge, the request first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            key_board.note_request(req_if.payload);
         if (rsp_if.valid && rsp_if.ready)
            key_board.check_result(rsp_if.payload);
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int unsigned stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            stall = steady ? 0 : pick_gap();
            rsp_if.ready <= (stall == 0);
            if (stall > 0)
               stall--;
         end
      end
   end

   initial begin
      int unsigned op;
      int unsigned burst;
      int unsigned waited;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      reset          <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: operations on an empty queue, unused codes, key extremes.
      send_item(OP_DEQUEUE, KEY_MAX);
      send_item(OP_PEEK, KEY_MIN);
      send_item(OP_SEARCH, 32'sd0);
      for (op = int'(OP_CLEAR) + 1; op < (1 << OP_W); op++)
         send_item(OP_W'(op), -32'sd1);
      send_item(OP_ENQUEUE, KEY_MIN);
      send_item(OP_ENQUEUE, KEY_MAX);
      send_item(OP_ENQUEUE, -32'sd1);
      send_item(OP_ENQUEUE, KEY_MAX);
      send_item(OP_PEEK, 32'sd0);
      send_item(OP_SEARCH, KEY_MAX);
      send_item(OP_SEARCH, -32'sd1);
      send_item(OP_SEARCH, 32'sd0);
      send_item(OP_DEQUEUE, 32'sd0);
      send_item(OP_PEEK, 32'sd0);
      send_item(OP_CLEAR, KEY_MIN);
      send_item(OP_PEEK, 32'sd0);
      send_item(OP_DEQUEUE, 32'sd0);

      // The receiver holds off while requests keep coming, so the block backs up.
      steady       = 1'b1;
      hold_results = 1'b1;
      repeat (40) send_item(pick_operation(), pick_key());

      // Random part: fills, drains and mixed runs, with and without idling.
      while (sent_items < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         burst  = $urandom_range(0, 9);
         if (burst < 2) begin
            fill_and_search();
         end else if (burst == 2) begin
            repeat (QUEUE_DEPTH + 2) send_item(OP_DEQUEUE, $urandom);
         end else begin
            repeat ($urandom_range(20, 40)) send_item(pick_operation(), pick_key());
         end
      end
      steady       = 1'b0;
      req_if.valid <= 1'b0;

      // Let the outstanding results come back, then let the bench settle.
      waited = 0;
      while (key_board.owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (key_board.owed_results.size() != 0)
         key_board.report($sformatf("%0d results never arrived",
                                    key_board.owed_results.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (key_board.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
src/fwks_pkg.sv
src/fwks_chan_if.sv
src/fwks_cell.sv
src/fwks_scan.sv
src/fifo_with_key_search_core.sv
sim/tb_fifo_with_key_search_core.sv
